// File: hw/rtl/mfs_pkg.sv
// shared types, constants and tables for the marker follow steering control
package mfs_pkg;

  localparam int unsigned IdW       = 10;
  localparam int unsigned XW        = 12;
  localparam int unsigned DistW     = 16;
  localparam int unsigned CmdW      = 8;
  localparam int unsigned CfgW      = 12;
  localparam int unsigned HalfW     = 11;
  localparam int unsigned CordW     = 32;
  localparam int unsigned AngW      = 21;
  localparam int unsigned SteerVW   = 24;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW     = $clog2(CordicSteps);
  localparam int unsigned LostFrames = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [XW-1:0]    ImageWidthRst = 12'd640;
  localparam logic [DistW-1:0] DistFar       = 16'd512;
  localparam logic [DistW-1:0] DistMid       = 16'd256;
  localparam logic [DistW-1:0] DistNear      = 16'd128;
  localparam logic [DistW-1:0] DistKeep      = 16'd384;
  localparam logic [CmdW-1:0]  SteerCenter   = 8'd90;
  localparam logic [CmdW-1:0]  ThrFar        = 8'd86;
  localparam logic [CmdW-1:0]  ThrMid        = 8'd88;
  localparam logic [CmdW-1:0]  ThrNear       = 8'd89;
  localparam logic [CmdW-1:0]  ThrStop       = 8'd91;
  localparam logic signed [SteerVW-1:0] SteerBase = 24'sd1474560;

  typedef enum logic [0:0] {
    CFG_TARGET_ID   = 1'b0,
    CFG_IMAGE_WIDTH = 1'b1
  } mfs_cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_NEVER = 2'd0,
    MODE_TRACK = 2'd1,
    MODE_KEEP  = 2'd2,
    MODE_IDLE  = 2'd3
  } mfs_mode_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_ROT  = 2'd1,
    B_FIN  = 2'd2
  } mfs_back_state_t;

  typedef struct packed {
    logic             seen;
    logic [XW-1:0]    x;
    logic [DistW-1:0] distance;
  } mfs_job_t;

  function automatic logic signed [AngW-1:0] mfs_atan(input logic [StepW-1:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      4'd0:    v = 21'sd184325;
      4'd1:    v = 21'sd108814;
      4'd2:    v = 21'sd57494;
      4'd3:    v = 21'sd29185;
      4'd4:    v = 21'sd14649;
      4'd5:    v = 21'sd7332;
      4'd6:    v = 21'sd3667;
      4'd7:    v = 21'sd1833;
      4'd8:    v = 21'sd917;
      4'd9:    v = 21'sd458;
      4'd10:   v = 21'sd229;
      4'd11:   v = 21'sd115;
      4'd12:   v = 21'sd57;
      4'd13:   v = 21'sd29;
      4'd14:   v = 21'sd14;
      4'd15:   v = 21'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/mfs_front.sv
// front end: target match, per-frame capture and job issue at frame end
module mfs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mfs_pkg::IdW-1:0]    target_id,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_marker_valid,
  input  logic [mfs_pkg::IdW-1:0]    in_marker_id,
  input  logic [mfs_pkg::XW-1:0]     in_center_x,
  input  logic [mfs_pkg::DistW-1:0]  in_distance,
  input  logic                       in_frame_end,
  input  logic                       q_full,
  output logic                       q_push,
  output mfs_pkg::mfs_job_t          q_job
);
  import mfs_pkg::*;

  logic             seen_r;
  logic [XW-1:0]    x_r;
  logic [DistW-1:0] dist_r;
  logic             accept;
  logic             hit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign hit      = in_marker_valid && (in_marker_id == target_id);
  assign q_push   = accept && in_frame_end;

  always_comb begin
    q_job.seen     = seen_r || hit;
    q_job.x        = hit ? in_center_x : x_r;
    q_job.distance = hit ? in_distance : dist_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      x_r    <= '0;
      dist_r <= '0;
    end else if (accept) begin
      if (hit) begin
        x_r    <= in_center_x;
        dist_r <= in_distance;
      end
      seen_r <= in_frame_end ? 1'b0 : (seen_r || hit);
    end
  end

endmodule

// File: hw/rtl/mfs_queue.sv
// small job queue between front and back
module mfs_queue #(
  parameter int unsigned DEPTH = mfs_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mfs_pkg::mfs_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output mfs_pkg::mfs_job_t pop_job
);
  import mfs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mfs_job_t      slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/mfs_back.sv
// back end: iterative arctangent, steering policy and output register
module mfs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mfs_pkg::XW-1:0]     image_width,
  input  logic                       q_valid,
  input  mfs_pkg::mfs_job_t          q_job,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mfs_pkg::CmdW-1:0]   out_steering,
  output logic [mfs_pkg::CmdW-1:0]   out_throttle,
  output logic [1:0]                 out_mode
);
  import mfs_pkg::*;

  mfs_back_state_t         state_r, state_nxt;
  mfs_job_t                job_r;
  logic signed [CordW-1:0] cx_r, cy_r;
  logic signed [AngW-1:0]  z_r;
  logic [StepW-1:0]        step_r;
  logic                    ever_r;
  logic [1:0]              fss_r;
  logic [CmdW-1:0]         hold_r;
  logic                    out_valid_r;
  logic [CmdW-1:0]         steer_r, thr_r;
  mfs_mode_t               mode_r;

  logic                    ld_out;
  logic                    last_step;
  logic [HalfW-1:0]        half;
  logic signed [XW:0]      num;
  logic                    need_rot;
  logic signed [CordW-1:0] xs, ys;
  logic signed [SteerVW-1:0] z_ext, steer_v;
  logic [CmdW-1:0]         steer_calc;
  logic [1:0]              fss_inc;
  logic [CmdW-1:0]         hold_nxt, steer_nxt, thr_nxt;
  mfs_mode_t               mode_nxt;
  logic                    ever_nxt;
  logic [1:0]              fss_nxt;

  assign half      = image_width[XW-1:1];
  assign num       = $signed({1'b0, q_job.x}) - $signed({2'b00, half});
  assign need_rot  = q_job.seen && (q_job.distance > DistNear) && (num != '0);
  assign last_step = (step_r == StepW'(CordicSteps - 1));
  assign xs        = cx_r >>> step_r;
  assign ys        = cy_r >>> step_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = need_rot ? B_ROT : B_FIN;
        end
      end
      B_ROT: begin
        if (last_step) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    q_pop  = 1'b0;
    ld_out = 1'b0;
    case (state_r)
      B_IDLE:  q_pop  = q_valid;
      B_FIN:   ld_out = !out_valid_r || !out_stall;
      default: begin
        q_pop  = 1'b0;
        ld_out = 1'b0;
      end
    endcase
  end

  // steering policy
  always_comb begin
    z_ext      = {{(SteerVW - AngW){z_r[AngW-1]}}, z_r};
    steer_v    = (job_r.distance > DistFar) ? SteerBase + z_ext
                                            : SteerBase + z_ext + (z_ext <<< 1);
    steer_calc = steer_v[SteerVW-1] ? '0 : steer_v[14 +: CmdW];
    fss_inc    = (fss_r == 2'd3) ? fss_r : fss_r + 2'd1;
    hold_nxt   = hold_r;
    ever_nxt   = ever_r;
    fss_nxt    = fss_r;
    thr_nxt    = ThrStop;
    mode_nxt   = MODE_IDLE;
    if (job_r.seen) begin
      ever_nxt = 1'b1;
      fss_nxt  = '0;
      mode_nxt = MODE_TRACK;
      if (job_r.distance > DistFar) begin
        thr_nxt  = ThrFar;
        hold_nxt = steer_calc;
      end else if (job_r.distance > DistMid) begin
        thr_nxt  = ThrMid;
        hold_nxt = steer_calc;
      end else if (job_r.distance > DistNear) begin
        thr_nxt  = ThrNear;
        hold_nxt = steer_calc;
      end
    end else begin
      fss_nxt = fss_inc;
      if (!ever_r) begin
        hold_nxt = SteerCenter;
        mode_nxt = MODE_NEVER;
      end else if ((fss_inc < 2'(LostFrames)) && (job_r.distance > DistKeep)) begin
        if (hold_r < SteerCenter) begin
          hold_nxt = hold_r + 1'b1;
        end else if (hold_r > SteerCenter) begin
          hold_nxt = hold_r - 1'b1;
        end
        thr_nxt  = ThrMid;
        mode_nxt = MODE_KEEP;
      end
    end
    steer_nxt = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      ever_r      <= 1'b0;
      fss_r       <= '0;
      hold_r      <= SteerCenter;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ld_out || (out_valid_r && out_stall);
      if (ld_out) begin
        ever_r <= ever_nxt;
        fss_r  <= fss_nxt;
        hold_r <= hold_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r  <= q_job;
      cx_r   <= {{(CordW - HalfW - 16){1'b0}}, half, 16'b0};
      cy_r   <= {{(CordW - XW - 1 - 16){num[XW]}}, num, 16'b0};
      z_r    <= '0;
      step_r <= '0;
    end else if (state_r == B_ROT) begin
      step_r <= step_r + 1'b1;
      if (!cy_r[CordW-1]) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        z_r  <= z_r + mfs_atan(step_r);
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        z_r  <= z_r - mfs_atan(step_r);
      end
    end
    if (ld_out) begin
      steer_r <= steer_nxt;
      thr_r   <= thr_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_steering = steer_r;
  assign out_throttle = thr_r;
  assign out_mode     = mode_r;

`ifndef SYNTHESIS
  a_rot_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROT && last_step) |=> (state_r == B_FIN))
    else $error("rotation did not end after last step");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == B_IDLE && q_valid))
    else $error("job taken outside idle");
  a_track_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mode_r == MODE_TRACK) |-> ever_r)
    else $error("tracking beat without target ever seen");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten");
`endif

endmodule

// File: hw/rtl/marker_follow_steering_control.sv
// top level of the marker follow steering control
// non frame-end beats are taken one per cycle while the job queue has room
// a frame-end beat gives one result beat: it goes through the queue, job
// pickup, 16 cordic iterations of the rotator, then the policy step
// frames without a target rotation skip the cordic iterations
// reset (synchronous, active low) clears the queue, the frame capture and the
// tracking state, sets held steering to 90, restores register defaults
module marker_follow_steering_control #(
  parameter int unsigned QUEUE_DEPTH = mfs_pkg::QueueDepth
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [mfs_pkg::CfgW-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_marker_valid,
  input  logic [mfs_pkg::IdW-1:0]    in_marker_id,
  input  logic [mfs_pkg::XW-1:0]     in_center_x,
  input  logic [mfs_pkg::DistW-1:0]  in_distance,
  input  logic                       in_frame_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mfs_pkg::CmdW-1:0]   out_steering,
  output logic [mfs_pkg::CmdW-1:0]   out_throttle,
  output logic [1:0]                 out_mode
);
  import mfs_pkg::*;

  logic [IdW-1:0] target_id_r;
  logic [XW-1:0]  image_width_r;
  logic           q_full, q_push, q_pop, q_valid;
  mfs_job_t       push_job, pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_id_r   <= '0;
      image_width_r <= ImageWidthRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_ID:   target_id_r   <= cfg_data[IdW-1:0];
        CFG_IMAGE_WIDTH: image_width_r <= cfg_data[XW-1:0];
        default:         target_id_r   <= target_id_r;
      endcase
    end
  end

  mfs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .target_id       (target_id_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_marker_valid (in_marker_valid),
    .in_marker_id    (in_marker_id),
    .in_center_x     (in_center_x),
    .in_distance     (in_distance),
    .in_frame_end    (in_frame_end),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  mfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (pop_job)
  );

  mfs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (image_width_r),
    .q_valid      (q_valid),
    .q_job        (pop_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_steering (out_steering),
    .out_throttle (out_throttle),
    .out_mode     (out_mode)
  );

endmodule
